### src/tcwt_pkg.sv
package tcwt_pkg;

  localparam int unsigned ConnEntries = 256;
  localparam int unsigned IdxW = (ConnEntries > 1) ? $clog2(ConnEntries) : 1;

  localparam logic [8:0] FlFin = 9'h001;
  localparam logic [8:0] FlSyn = 9'h002;
  localparam logic [8:0] FlRst = 9'h004;
  localparam logic [8:0] FlPsh = 9'h008;
  localparam logic [8:0] FlAck = 9'h010;
  localparam logic [8:0] FlUrg = 9'h020;

  localparam logic [3:0] MaxShift   = 4'd14;
  localparam logic [7:0] MarkKnown  = 8'h80;
  localparam logic [7:0] MarkUnknown = 8'h40;
  localparam logic [31:0] AckSlack  = 32'd67035;

  localparam logic [3:0] StClosed    = 4'd0;
  localparam logic [3:0] StSynSent   = 4'd2;
  localparam logic [3:0] StEstab     = 4'd4;
  localparam logic [3:0] StClosing   = 4'd7;
  localparam logic [3:0] StFinWait2  = 4'd9;
  localparam logic [3:0] StTimeWait  = 4'd10;

  localparam logic [2:0] VInvalid  = 3'd0;
  localparam logic [2:0] VNew      = 3'd1;
  localparam logic [2:0] VValidNew = 3'd2;
  localparam logic [2:0] VValid    = 3'd3;
  localparam logic [2:0] VCreated  = 3'd4;
  localparam logic [2:0] VRefused  = 3'd5;

  localparam logic [0:0] RegTps = 1'b0;
  localparam logic [0:0] RegNet = 1'b1;

  typedef struct packed {
    logic [3:0]  st;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [15:0] mw;
    logic [7:0]  mk;
  } peer_t;

  typedef struct packed {
    logic            op;
    logic [IdxW-1:0] idx;
    logic            rep;
    logic [8:0]      fl;
    logic [31:0]     seq;
    logic [31:0]     ack;
    logic [15:0]     win;
    logic [15:0]     len;
    logic            opt_p;
    logic [7:0]      opt_sh;
    logic [63:0]     now;
  } item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        ev;
    logic [63:0] exp;
    logic [3:0]  st0;
    logic [3:0]  st1;
  } res_t;

  // seconds classes for the timeout multiplier
  typedef enum logic [2:0] {
    TmoNone, Tmo30, Tmo45, Tmo900, Tmo86400, TmoNew
  } tmo_e;

  typedef enum logic [1:0] {
    CtlIdle, CtlRead, CtlCalc, CtlOut
  } ctl_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic fin;
  } cmd_t;

  function automatic logic seq_geq(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    t = a - b;
    return ~t[31];
  endfunction

  function automatic logic bad_flags(logic [8:0] f);
    logic b;
    b = 1'b0;
    if ((f & FlSyn) != 0) begin
      if ((f & (FlRst | FlFin)) != 0) b = 1'b1;
    end else if ((f & (FlAck | FlRst)) == 0) begin
      b = 1'b1;
    end
    if ((f & FlAck) == 0 && (f & (FlFin | FlPsh | FlUrg)) != 0) b = 1'b1;
    return b;
  endfunction

  function automatic logic [31:0] one_min(logic [31:0] v);
    return (v == 0) ? 32'd1 : v;
  endfunction

endpackage

### src/tcwt_ctrl.sv
module tcwt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output tcwt_pkg::cmd_t     cmd_o
);
  import tcwt_pkg::*;

  ctl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= CtlIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CtlIdle: if (in_valid_i) state_d = CtlRead;
      CtlRead: state_d = CtlCalc;
      CtlCalc: state_d = CtlOut;
      CtlOut:  if (out_free_i) state_d = CtlIdle;
      default: state_d = CtlIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      CtlIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      CtlCalc: cmd_o.calc = 1'b1;
      CtlOut:  cmd_o.fin = out_free_i;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == CtlRead) else $error("load not followed by read");
  a_calc_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.calc |=> state_q == CtlOut) else $error("calc not followed by out");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.calc && in_ready_o)) else $error("ready during calc");
`endif
endmodule

### src/tcwt_dp.sv
module tcwt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcwt_pkg::cmd_t       cmd_i,
  input  tcwt_pkg::item_t      item_i,
  input  logic [29:0]          tps_i,
  input  logic [39:0]          net_i,
  output logic                 out_free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tcwt_pkg::res_t       res_o
);
  import tcwt_pkg::*;

  peer_t mem0 [ConnEntries];
  peer_t mem1 [ConnEntries];
  item_t it_q;
  peer_t p0_q, p1_q;
  peer_t n0_q, n1_q;
  logic  wr_q, wr_d;
  res_t  r_q;
  logic [63:0] prod_q;
  logic  rv_q;
  logic  busy_q;

  // table read port and write-back port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p0_q <= mem0[item_i.idx];
      p1_q <= mem1[item_i.idx];
    end
    if (wr_q) begin
      mem0[it_q.idx] <= n0_q;
      mem1[it_q.idx] <= n1_q;
    end
  end

  always_ff @(posedge clk_i) if (cmd_i.load) it_q <= item_i;

  // main step
  peer_t s, d, n0, n1;
  res_t  r;
  tmo_e  tmo;
  logic  wr;
  logic [7:0]  opt;
  logic [3:0]  sws, dws, shc;
  logic [31:0] w, endv, seqv, ackv, top, diff, dwin, swin;
  logic [31:0] lo_s_orig;
  logic        okA, okB, skew_ok;
  logic [8:0]  fl;
  logic        done;
  logic [31:0] neg_lim;
  logic [47:0] pos_lim;
  logic [3:0]  a, b;

  always_comb begin
    fl = it_q.fl;
    opt = it_q.opt_p ? (MarkKnown | {4'h0, (it_q.opt_sh > {4'h0, MaxShift}) ? MaxShift :
                                          it_q.opt_sh[3:0]}) : 8'h00;
    s = it_q.rep ? p1_q : p0_q;
    d = it_q.rep ? p0_q : p1_q;
    r = '0; r.verdict = VValid; tmo = TmoNone; wr = 1'b0; done = 1'b0;
    sws = 4'd0; dws = 4'd0; shc = 4'd0;
    w = {16'h0, it_q.win}; endv = '0; seqv = it_q.seq; ackv = it_q.ack; top = '0;
    diff = '0; dwin = '0; swin = '0; okA = 0; okB = 0; skew_ok = 0;
    neg_lim = '0; pos_lim = '0; a = '0; b = '0; lo_s_orig = '0;
    n0 = p0_q; n1 = p1_q;
    if (it_q.op) begin
      if (bad_flags(fl) || ((fl & FlSyn) != 0 && (fl & FlAck) != 0)) begin
        r.verdict = VRefused;
      end else begin
        wr = 1'b1;
        n0.lo = it_q.seq;
        n0.hi = it_q.seq + {16'h0, it_q.len} + 32'd1;
        n1.lo = '0;
        if ((fl & FlSyn) != 0) begin
          n0.hi = n0.hi + 32'd1; n0.mk = opt; n1.mk = '0;
        end else begin
          n0.mk = MarkUnknown; n1.mk = MarkUnknown;
        end
        w = one_min(w);
        shc = n0.mk[3:0];
        if (shc != 0) w = (w + (32'd1 << shc) - 32'd1) >> shc;
        n0.mw = w[15:0];
        if ((fl & FlFin) != 0) n0.hi = n0.hi + 32'd1;
        n1.hi = 32'd1; n1.mw = 16'd1;
        n0.st = StSynSent; n1.st = StClosed;
        r.verdict = VCreated; r.ev = 1'b1; tmo = TmoNew;
      end
    end else begin
      if (bad_flags(fl)) begin
        r.verdict = VInvalid; done = 1'b1;
      end else if ((fl & (FlSyn | FlAck)) == FlSyn) begin
        if (d.st >= StFinWait2 && s.st >= StFinWait2) begin
          s.st = StClosed; d.st = StClosed; r.verdict = VNew; done = 1'b1; wr = 1'b1;
        end else if (s.st <= StSynSent) begin
          s.st = StSynSent; r.verdict = VValidNew; r.ev = 1'b1; tmo = Tmo30;
          done = 1'b1; wr = 1'b1;
        end
      end
      if (!done) begin
        wr = 1'b1;
        if ((fl & FlSyn) == 0) begin
          if (s.mk[7] && d.mk[7]) begin
            sws = s.mk[3:0]; dws = d.mk[3:0];
          end else if (s.mk[6] && d.mk[6]) begin
            sws = MaxShift; dws = MaxShift;
          end
        end
        endv = it_q.seq + {16'h0, it_q.len};
        if ((fl & FlSyn) != 0) endv = endv + 32'd1;
        if (s.st < StSynSent) begin
          if ((fl & FlSyn) != 0 && d.mk[7]) begin
            s.mk = opt;
            if (opt[7]) begin
              sws = opt[3:0];
              w = (w + (32'd1 << sws) - 32'd1) >> sws;
              dws = d.mk[3:0];
            end else begin
              d.mw = 16'(({16'h0, d.mw}) << d.mk[3:0]);
              d.mk = '0;
            end
          end
          if ((fl & FlFin) != 0) endv = endv + 32'd1;
          s.lo = it_q.seq;
          s.st = StSynSent;
          dwin = 32'({16'h0, d.mw} << dws);
          top = endv + one_min(dwin);
          if (s.hi == 32'd1 || seq_geq(top, s.hi)) s.hi = top;
          if (w > {16'h0, s.mw}) s.mw = w[15:0];
        end else if ((fl & FlFin) != 0) begin
          endv = endv + 32'd1;
        end
        if ((fl & FlAck) == 0 || (it_q.ack == 0 && (fl & FlRst) != 0)) ackv = d.lo;
        if (it_q.seq == endv) begin
          seqv = s.lo; endv = s.lo;
        end
        diff = d.lo - ackv;
        // skew is diff read as signed 32
        neg_lim = 32'hFFFF_FFFF - AckSlack + 32'd1;
        pos_lim = {16'h0, AckSlack} << sws;
        if (diff[31]) skew_ok = (diff >= neg_lim);
        else skew_ok = ({16'h0, diff} <= pos_lim);
        dwin = 32'({16'h0, d.mw} << dws);
        lo_s_orig = s.lo;
        okA = seq_geq(s.hi, endv) && seq_geq(seqv, s.lo - dwin) && skew_ok &&
              ((fl & FlRst) == 0 || it_q.seq == s.lo || it_q.seq == s.lo + 32'd1 ||
               it_q.seq + 32'd1 == s.lo);
        okB = (d.st < StSynSent || d.st >= StFinWait2 || s.st >= StFinWait2) &&
              seq_geq(s.hi + AckSlack, endv) && seq_geq(seqv, s.lo - AckSlack);
        swin = 32'(w << sws);
        if (okA || okB) begin
          if (s.mw < w) s.mw = w[15:0];
          if (!seq_geq(lo_s_orig, endv)) s.lo = endv;
          if (seq_geq(ackv + swin, d.hi)) d.hi = ackv + one_min(swin);
          if (okA) begin
            if ((fl & FlSyn) != 0 && s.st < StSynSent) s.st = StSynSent;
          end
          if ((fl & FlFin) != 0 && s.st < StClosing) s.st = StClosing;
          if (okA && (fl & FlAck) != 0) begin
            if (d.st == StSynSent) d.st = StEstab;
            else if (d.st == StClosing) d.st = StFinWait2;
          end
          if ((fl & FlRst) != 0) begin
            s.st = StTimeWait; d.st = StTimeWait;
          end
          if (okA) begin
            a = s.st; b = d.st; r.ev = 1'b1;
            if (a >= StFinWait2 && b >= StFinWait2) tmo = Tmo30;
            else if (a >= StClosing && b >= StClosing) tmo = Tmo45;
            else if (a < StEstab || b < StEstab) tmo = Tmo30;
            else if (a >= StClosing || b >= StClosing) tmo = Tmo900;
            else tmo = Tmo86400;
          end
        end else begin
          r.verdict = VInvalid;
        end
      end
      if (it_q.rep) begin n1 = s; n0 = d; end
      else begin n0 = s; n1 = d; end
    end
    wr_d = wr;
    if (r.verdict != VRefused) begin
      r.st0 = n0.st; r.st1 = n1.st;
    end
  end

  // timeout product, registered before the final add
  logic [16:0] mult_k;
  always_comb begin
    case (tmo)
      Tmo30:    mult_k = 17'd30;
      Tmo45:    mult_k = 17'd45;
      Tmo900:   mult_k = 17'd900;
      Tmo86400: mult_k = 17'd86400;
      default:  mult_k = 17'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      n0_q <= n0; n1_q <= n1; r_q <= r;
      prod_q <= (tmo == TmoNew) ? {24'h0, net_i} :
                64'({30'h0, mult_k} * {17'h0, tps_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rv_q <= 1'b0; busy_q <= 1'b0;
    end else begin
      wr_q <= cmd_i.calc & wr_d;
      if (cmd_i.fin) rv_q <= 1'b1;
      else if (out_ready_i) rv_q <= 1'b0;
      busy_q <= cmd_i.calc;
    end
  end

  res_t ro_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      ro_q.verdict <= r_q.verdict;
      ro_q.ev      <= r_q.ev;
      ro_q.exp     <= r_q.ev ? (it_q.now + prod_q) : 64'd0;
      ro_q.st0     <= r_q.st0;
      ro_q.st1     <= r_q.st1;
    end
  end

  assign out_free_o = !rv_q || out_ready_i;
  assign out_valid_o = rv_q;
  assign res_o = ro_q;

`ifndef SYNTHESIS
  a_no_ev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && !ro_q.ev |-> ro_q.exp == 64'd0) else $error("expiry without flag");
  a_wr_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q |-> busy_q) else $error("table write outside step");
  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && ro_q.verdict == VRefused |-> !ro_q.ev) else $error("refused with expiry");
`endif
endmodule

### src/tcp_conn_window_tracker.sv
// channel | dir | tdata / tuser fields
// s_axis  | in  | tuser: op; tdata: conn_index,reply,flags,seq,ack,window,len,opt_p,opt_sh,now
// m_axis  | out | tdata: verdict,expiry_valid,expiry_time,orig_state,reply_state
// apb     | in  | 0x0 ticks_per_second, 0x8 new_entry_timeout
// Each word passes through accept, table read, update and result register in turn.
// The table read-modify-write sets the rate; entries are two peer memories.
// Reset clears control and loads the timing register defaults; table contents stay undefined until created.
// A stalled result holds the block in its output state.
module tcp_conn_window_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op
  input  logic [0:0]   s_axis_tuser,
  // conn_index, reply, flags, seq_number, ack_number, window,
  // payload_len, scale_opt_present, scale_opt_shift, now (lowest first)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // verdict, expiry_valid, expiry_time, orig_peer_state, reply_peer_state
  output logic [79:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import tcwt_pkg::*;

  logic [29:0] tps_q;
  logic [39:0] net_q;
  cmd_t  cmd;
  item_t item;
  res_t  res;
  logic  free;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= 30'd1000; net_q <= 40'd30000;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:3])
        RegTps: tps_q <= pwdata[29:0];
        RegNet: net_q <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:3])
      RegTps:  prdata = {34'h0, tps_q};
      RegNet:  prdata = {24'h0, net_q};
      default: prdata = '0;
    endcase
  end

  assign item.op     = s_axis_tuser[0];
  assign item.idx    = s_axis_tdata[0 +: IdxW];
  assign item.rep    = s_axis_tdata[8];
  assign item.fl     = s_axis_tdata[17:9];
  assign item.seq    = s_axis_tdata[49:18];
  assign item.ack    = s_axis_tdata[81:50];
  assign item.win    = s_axis_tdata[97:82];
  assign item.len    = s_axis_tdata[113:98];
  assign item.opt_p  = s_axis_tdata[114];
  assign item.opt_sh = s_axis_tdata[122:115];
  assign item.now    = s_axis_tdata[186:123];

  tcwt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_free_i(free), .cmd_o(cmd)
  );

  tcwt_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(item),
    .tps_i(tps_q), .net_i(net_q),
    .out_free_o(free), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {4'h0, res.st1, res.st0, res.exp, res.ev, res.verdict};
endmodule

### sim/tb_tcp_conn_window_tracker.sv
module tb_tcp_conn_window_tracker;
  import tcwt_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic        op;
    logic [7:0]  idx;
    logic        rep;
    logic [8:0]  fl;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [15:0] len;
    logic        opt_p;
    logic [7:0]  opt_sh;
    logic [63:0] now;
  } pkt_t;

  typedef struct {
    logic [2:0]  verdict;
    logic        ev;
    logic [63:0] exp;
    logic [3:0]  st0;
    logic [3:0]  st1;
  } verdict_t;

  class conn_scoreboard;
    logic [3:0]  st[512];
    logic [31:0] lo[512];
    logic [31:0] hi[512];
    logic [15:0] mw[512];
    logic [7:0]  mk[512];
    bit          created[256];
    logic [63:0] tps = 64'd1000;
    logic [63:0] net = 64'd30000;
    verdict_t    pending[$];
    int          errors = 0;

    function bit ahead(logic [31:0] a, logic [31:0] b);
      logic [31:0] t;
      t = a - b;
      return !t[31];
    endfunction

    function bit flags_rejected(logic [8:0] f);
      bit r;
      r = 0;
      if ((f & FlSyn) != 0) begin
        if ((f & (FlRst | FlFin)) != 0) r = 1;
      end else if ((f & (FlAck | FlRst)) == 0) begin
        r = 1;
      end
      if ((f & FlAck) == 0 && (f & (FlFin | FlPsh | FlUrg)) != 0) r = 1;
      return r;
    endfunction

    function logic [31:0] nonzero(logic [31:0] v);
      return (v == 0) ? 32'd1 : v;
    endfunction

    function logic [31:0] round_win(logic [31:0] w, logic [3:0] sh);
      return (w + (32'd1 << sh) - 32'd1) >> sh;
    endfunction

    function void note_packet(pkt_t p);
      int s, d;
      logic [31:0] w, seq, ack, tail, orig, top, diff;
      logic [3:0] sws, dws, a, b;
      logic [7:0] opt;
      logic [2:0] v;
      logic ev, stop;
      logic [63:0] ex;
      longint sk;
      bit syn, ackf, fin, rst, ok;
      verdict_t r;
      w = {16'd0, p.win};
      seq = p.seq;
      ack = p.ack;
      syn = (p.fl & FlSyn) != 0;
      ackf = (p.fl & FlAck) != 0;
      fin = (p.fl & FlFin) != 0;
      rst = (p.fl & FlRst) != 0;
      opt = p.opt_p ? (((p.opt_sh > 14) ? 8'd14 : p.opt_sh) | MarkKnown) : 8'd0;
      if (p.op) begin
        if (flags_rejected(p.fl) || (syn && ackf)) begin
          pending.push_back('{VRefused, 1'b0, 64'd0, 4'd0, 4'd0});
          return;
        end
        s = p.idx * 2;
        d = s + 1;
        lo[s] = seq;
        hi[s] = seq + p.len + 32'd1;
        lo[d] = 0;
        if (syn) begin
          hi[s]++;
          mk[s] = opt;
          mk[d] = 0;
        end else begin
          mk[s] = MarkUnknown;
          mk[d] = MarkUnknown;
        end
        w = nonzero(w);
        sws = mk[s][3:0];
        if (sws != 0) w = round_win(w, sws);
        mw[s] = w[15:0];
        if (fin) hi[s]++;
        hi[d] = 1;
        mw[d] = 1;
        st[s] = StSynSent;
        st[d] = StClosed;
        created[p.idx] = 1;
        pending.push_back('{VCreated, 1'b1, p.now + net, StSynSent, StClosed});
        return;
      end
      s = p.idx * 2 + p.rep;
      d = p.idx * 2 + (p.rep ^ 1);
      v = VValid;
      ev = 0;
      ex = 0;
      sws = 0;
      dws = 0;
      stop = 0;
      if (flags_rejected(p.fl)) begin
        v = VInvalid;
        stop = 1;
      end else if (syn && !ackf) begin
        if (st[d] >= StFinWait2 && st[s] >= StFinWait2) begin
          st[s] = StClosed;
          st[d] = StClosed;
          v = VNew;
          stop = 1;
        end else if (st[s] <= StSynSent) begin
          st[s] = StSynSent;
          v = VValidNew;
          ev = 1;
          ex = p.now + 64'd30 * tps;
          stop = 1;
        end
      end
      if (!stop) begin
        if (!syn) begin
          if (mk[s][7] && mk[d][7]) begin
            sws = mk[s][3:0];
            dws = mk[d][3:0];
          end else if (mk[s][6] && mk[d][6]) begin
            sws = MaxShift;
            dws = MaxShift;
          end
        end
        orig = seq;
        tail = seq + p.len;
        if (syn) tail++;
        if (st[s] < StSynSent) begin
          if (syn && mk[d][7]) begin
            mk[s] = opt;
            if (opt[7]) begin
              sws = opt[3:0];
              w = round_win(w, sws);
              dws = mk[d][3:0];
            end else begin
              mw[d] = 16'({16'd0, mw[d]} << mk[d][3:0]);
              mk[d] = 0;
            end
          end
          if (fin) tail++;
          lo[s] = seq;
          st[s] = StSynSent;
          top = tail + nonzero({16'd0, mw[d]} << dws);
          if (hi[s] == 32'd1 || ahead(top, hi[s])) hi[s] = top;
          if (w > {16'd0, mw[s]}) mw[s] = w[15:0];
        end else if (fin) begin
          tail++;
        end
        if (!ackf || (ack == 0 && rst)) ack = lo[d];
        if (seq == tail) begin
          seq = lo[s];
          tail = seq;
        end
        diff = lo[d] - ack;
        sk = longint'($signed(diff));
        ok = ahead(hi[s], tail) && ahead(seq, lo[s] - ({16'd0, mw[d]} << dws))
             && sk >= -longint'(AckSlack) && sk <= (longint'(AckSlack) << sws)
             && (!rst || orig == lo[s] || orig == lo[s] + 32'd1 || orig + 32'd1 == lo[s]);
        if (ok) begin
          if ({16'd0, mw[s]} < w) mw[s] = w[15:0];
          if (!ahead(lo[s], tail)) lo[s] = tail;
          if (ahead(ack + (w << sws), hi[d])) hi[d] = ack + nonzero(w << sws);
          if (syn && st[s] < StSynSent) st[s] = StSynSent;
          if (fin && st[s] < StClosing) st[s] = StClosing;
          if (ackf) begin
            if (st[d] == StSynSent) st[d] = StEstab;
            else if (st[d] == StClosing) st[d] = StFinWait2;
          end
          if (rst) begin
            st[s] = StTimeWait;
            st[d] = StTimeWait;
          end
          a = st[s];
          b = st[d];
          ev = 1;
          if (a >= StFinWait2 && b >= StFinWait2) ex = p.now + 64'd30 * tps;
          else if (a >= StClosing && b >= StClosing) ex = p.now + 64'd45 * tps;
          else if (a < StEstab || b < StEstab) ex = p.now + 64'd30 * tps;
          else if (a >= StClosing || b >= StClosing) ex = p.now + 64'd900 * tps;
          else ex = p.now + 64'd86400 * tps;
        end else if ((st[d] < StSynSent || st[d] >= StFinWait2 || st[s] >= StFinWait2)
                     && ahead(hi[s] + AckSlack, tail) && ahead(seq, lo[s] - AckSlack)) begin
          if ({16'd0, mw[s]} < w) mw[s] = w[15:0];
          if (!ahead(lo[s], tail)) lo[s] = tail;
          if (ahead(ack + (w << sws), hi[d])) hi[d] = ack + nonzero(w << sws);
          if (fin && st[s] < StClosing) st[s] = StClosing;
          if (rst) begin
            st[s] = StTimeWait;
            st[d] = StTimeWait;
          end
        end else begin
          v = VInvalid;
        end
      end
      r = '{v, ev, ev ? ex : 64'd0, st[p.idx * 2], st[p.idx * 2 + 1]};
      pending.push_back(r);
    endfunction

    function void check_result(logic [79:0] data);
      verdict_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $realtime, data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[2:0] != e.verdict) begin
        $display("%0t: verdict expected %0d actual %0d", $realtime, e.verdict, data[2:0]);
        errors++;
      end
      if (data[3] != e.ev) begin
        $display("%0t: expiry_valid expected %0d actual %0d", $realtime, e.ev, data[3]);
        errors++;
      end
      if (data[67:4] != e.exp) begin
        $display("%0t: expiry_time expected %h actual %h", $realtime, e.exp, data[67:4]);
        errors++;
      end
      if (data[71:68] != e.st0) begin
        $display("%0t: orig state expected %0d actual %0d", $realtime, e.st0, data[71:68]);
        errors++;
      end
      if (data[75:72] != e.st1) begin
        $display("%0t: reply state expected %0d actual %0d", $realtime, e.st1, data[75:72]);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [0:0]   s_axis_tuser = '0;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  conn_scoreboard sb = new();
  int unsigned    cycles = 0;
  int             burst_left = 0;
  bit             hold_req = 0;

  tcp_conn_window_tracker u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // receiver: stall pattern is redrawn at random; one long hold-off on request
  initial begin
    int mode;
    int hold;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) begin
        hold_req = 0;
        hold = 400;
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [29:0] tps, input logic [39:0] net);
    apb_write({RegTps, 3'b000}, {34'd0, tps});
    apb_write({RegNet, 3'b000}, {24'd0, net});
    sb.tps = {34'd0, tps};
    sb.net = {24'd0, net};
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // hold the word until taken; idle between some bursts
  task automatic send(input pkt_t p);
    logic [191:0] t;
    t = {5'd0, p.now, p.opt_sh, p.opt_p, p.len, p.win, p.ack, p.seq, p.fl, p.rep, p.idx};
    s_axis_tdata <= t;
    s_axis_tuser <= p.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_packet(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  function automatic pkt_t blank_pkt(logic op, logic [7:0] idx, logic rep, logic [8:0] fl);
    pkt_t p;
    p.op = op;
    p.idx = idx;
    p.rep = rep;
    p.fl = fl;
    p.seq = $urandom();
    p.ack = $urandom();
    p.win = 16'($urandom());
    p.len = 16'($urandom_range(0, 1500));
    p.opt_p = 1'($urandom_range(0, 1));
    p.opt_sh = 8'($urandom_range(0, 15));
    p.now = {32'($urandom()), 32'($urandom())};
    return p;
  endfunction

  // mostly in-window traffic on live entries, some noise
  function automatic pkt_t random_pkt();
    pkt_t p;
    logic [8:0] good[8];
    int s, d, k;
    good = '{FlSyn, FlSyn | FlAck, FlAck, FlAck | FlPsh, FlFin | FlAck, FlRst, FlRst | FlAck,
             FlAck | FlUrg};
    k = $urandom_range(0, 255);
    if ($urandom_range(0, 99) < 15 || !sb.created[k]) begin
      p = blank_pkt(1'b1, 8'(k), 1'($urandom_range(0, 1)), FlSyn);
      case ($urandom_range(0, 5))
        0: p.fl = FlAck;
        1: p.fl = 9'($urandom_range(0, 511));
        2: p.fl = FlAck | FlFin;
        default: ;
      endcase
    end else begin
      p = blank_pkt(1'b0, 8'(k), 1'($urandom_range(0, 1)), good[$urandom_range(0, 7)]);
      if ($urandom_range(0, 9) == 0) p.fl = 9'($urandom_range(0, 511));
      s = k * 2 + p.rep;
      d = k * 2 + (p.rep ^ 1);
      if ($urandom_range(0, 9) < 8) p.seq = sb.lo[s] + $urandom_range(0, 2000) - 200;
      if ($urandom_range(0, 9) < 8) p.ack = sb.lo[d] + $urandom_range(0, 2000) - 200;
      if ($urandom_range(0, 19) == 0) p.len = 16'($urandom());
      if ($urandom_range(0, 9) == 0) p.opt_sh = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) p.ack = 0;
    end
    if ($urandom_range(0, 3) == 0) p.win = 16'($urandom_range(0, 3));
    return p;
  endfunction

  task automatic directed();
    pkt_t p;
    p = blank_pkt(1'b1, 8'd3, 1'b0, FlSyn | FlAck);
    send(p);
    p = blank_pkt(1'b1, 8'd3, 1'b0, FlFin);
    send(p);
    p = blank_pkt(1'b1, 8'd0, 1'b1, FlSyn);
    p.seq = 32'hffff_ffff;
    p.win = 16'hffff;
    p.len = 16'hffff;
    p.opt_p = 1'b1;
    p.opt_sh = 8'hff;
    p.now = 64'hffff_ffff_ffff_ffff;
    send(p);
    p = blank_pkt(1'b0, 8'd0, 1'b1, FlSyn | FlAck);
    p.ack = sb.lo[0] + 1;
    p.opt_p = 1'b1;
    p.opt_sh = 8'd7;
    p.win = 16'h0;
    send(p);
    p = blank_pkt(1'b0, 8'd0, 1'b0, FlAck | FlPsh);
    p.seq = sb.lo[0];
    p.ack = sb.lo[1];
    send(p);
    p = blank_pkt(1'b0, 8'd0, 1'b0, FlFin | FlAck);
    p.seq = sb.lo[0];
    p.ack = sb.lo[1];
    send(p);
    p = blank_pkt(1'b0, 8'd0, 1'b1, FlFin | FlAck);
    p.seq = sb.lo[1];
    p.ack = sb.lo[0];
    send(p);
    p = blank_pkt(1'b0, 8'd0, 1'b0, FlAck);
    p.seq = sb.lo[0];
    p.ack = sb.lo[1];
    send(p);
    p = blank_pkt(1'b0, 8'd0, 1'b0, FlSyn);
    send(p);
    p = blank_pkt(1'b1, 8'd255, 1'b0, FlAck | FlFin | FlUrg);
    p.seq = 32'h0;
    send(p);
    p = blank_pkt(1'b0, 8'd255, 1'b1, FlAck);
    p.seq = 32'h0;
    p.win = 16'hffff;
    send(p);
    p = blank_pkt(1'b0, 8'd255, 1'b0, FlRst);
    p.seq = sb.lo[510];
    p.ack = 0;
    send(p);
    p = blank_pkt(1'b0, 8'd255, 1'b0, 9'h1ff);
    send(p);
    p = blank_pkt(1'b0, 8'd255, 1'b1, FlSyn);
    send(p);
    p = blank_pkt(1'b1, 8'd1, 1'b0, FlSyn);
    p.opt_p = 1'b0;
    send(p);
    p = blank_pkt(1'b0, 8'd1, 1'b1, FlSyn);
    p.opt_p = 1'b1;
    p.opt_sh = 8'd14;
    send(p);
    p = blank_pkt(1'b0, 8'd1, 1'b1, FlRst | FlAck);
    p.seq = sb.lo[3] + 1;
    send(p);
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    bit ok;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_timing(30'd1, 40'd0);
    directed();
    drain();
    set_timing(30'h3fff_ffff, 40'hff_ffff_ffff);
    for (int i = 0; i < 200; i++) begin
      if (i == 100) hold_req = 1;
      send(random_pkt());
    end
    s_axis_tvalid <= 1'b0;
    drain();
    set_timing(30'd1000, 40'd30000);
    for (int i = 0; i < 200; i++) send(random_pkt());
    s_axis_tvalid <= 1'b0;
    drain();
    set_timing(30'($urandom()), {8'($urandom()), 32'($urandom())});
    for (int i = 0; i < 200; i++) send(random_pkt());
    s_axis_tvalid <= 1'b0;
    drain();
    ok = (sb.errors == 0) && (sb.pending.size() == 0);
    if (ok) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
